### rtl/itsrc_pkg.sv
// Shared types, constants and checksum helpers for the IPv4/TCP source-rewrite
// checksum block. No dependencies.
package itsrc_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;
  localparam logic [7:0]  PROTO_TCP            = 8'd6;
  localparam logic [15:0] MIN_PACKET_BYTES     = 16'd40;
  localparam logic [6:0]  IP_MIN_HDR_BYTES     = 7'd20;
  localparam int unsigned CFG_IDX_W            = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEW_SRC_ADDR  = 2'd0,
    REG_NEW_SRC_PORT  = 2'd1,
    REG_ADDR_REPL_EN  = 2'd2,
    REG_PORT_REPL_EN  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        length_ok;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic [15:0] received_bytes;
  } out_t;

  typedef struct packed {
    logic [31:0] new_source_address;
    logic [15:0] new_source_port;
    logic        replace_address_enable;
    logic        replace_port_enable;
  } cfg_t;

  // End-of-packet record handed from the byte accumulator to the finisher.
  typedef struct packed {
    logic [15:0] count;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [15:0] total_length;
    logic [15:0] ip_sum;
    logic [15:0] tcp_sum;
  } fin_t;

  // Ones'-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    oc_add = t[15:0] + {15'd0, t[16]};
  endfunction

  // Even offsets are the high byte of a 16-bit word.
  function automatic logic [15:0] place_byte(input logic odd, input logic [7:0] b);
    place_byte = odd ? {8'd0, b} : {b, 8'd0};
  endfunction

  // Header length in bytes; nibbles below five count as a 20-byte header.
  function automatic logic [5:0] eff_len(input logic [3:0] words);
    eff_len = (words < 4'd5) ? 6'd20 : {words, 2'b00};
  endfunction

endpackage

### rtl/itsrc_accum.sv
// Per-byte accumulator: offset, header lengths, total length, both running sums.
// Emits one end-of-packet record per last byte. Depends on itsrc_pkg.
module itsrc_accum #(
  parameter int unsigned MAX_PACKET_BYTES = itsrc_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  itsrc_pkg::cfg_t  cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  itsrc_pkg::in_t   in_data,
  output logic             fin_valid,
  output itsrc_pkg::fin_t  fin_data,
  input  logic             fin_pop
);

  localparam logic [15:0] MAX_OFF      = 16'(MAX_PACKET_BYTES);
  localparam logic [15:0] OFF_VER_IHL  = 16'd0;
  localparam logic [15:0] OFF_TLEN_HI  = 16'd2;
  localparam logic [15:0] OFF_TLEN_LO  = 16'd3;
  localparam logic [15:0] OFF_IPCS_HI  = 16'd10;
  localparam logic [15:0] OFF_IPCS_LO  = 16'd11;
  localparam logic [15:0] OFF_SRC_LO   = 16'd12;
  localparam logic [15:0] OFF_SRC_HI   = 16'd15;
  localparam logic [15:0] OFF_DST_HI   = 16'd19;
  localparam logic [15:0] SEG_SPORT_HI = 16'd0;
  localparam logic [15:0] SEG_SPORT_LO = 16'd1;
  localparam logic [15:0] SEG_DOFF     = 16'd12;
  localparam logic [15:0] SEG_CS_HI    = 16'd16;
  localparam logic [15:0] SEG_CS_LO    = 16'd17;

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [3:0]  doff_r, doff_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] ip_sum_r, ip_sum_nxt;
  logic [15:0] tcp_sum_r, tcp_sum_nxt;
  logic        fin_valid_r, fin_valid_nxt;
  itsrc_pkg::fin_t fin_r, fin_nxt;

  logic        take, active;
  logic [7:0]  b, vb, tv, addr_byte;
  logic [3:0]  ihl_n, doff_n;
  logic [15:0] tlen_n, ip_sum_n, tcp_sum_n;
  logic [15:0] ip_len, seg_off, tcp_end;
  logic [6:0]  tcp_hdr;
  logic        in_seg, in_pseudo;
  logic [3:0]  ihl_u, doff_u;
  logic [15:0] tlen_u, ip_sum_u, tcp_sum_u, count_u;

  assign take     = in_valid && !in_stall;
  assign in_stall = fin_valid_r && !fin_pop;
  assign active   = byte_offset_r < MAX_OFF;
  assign b        = in_data.data_byte;

  always_comb begin
    case (byte_offset_r[1:0])
      2'd0:    addr_byte = cfg.new_source_address[31:24];
      2'd1:    addr_byte = cfg.new_source_address[23:16];
      2'd2:    addr_byte = cfg.new_source_address[15:8];
      default: addr_byte = cfg.new_source_address[7:0];
    endcase
  end

  always_comb begin
    ihl_n  = (byte_offset_r == OFF_VER_IHL) ? b[3:0] : ihl_r;
    tlen_n = tlen_r;
    if (byte_offset_r == OFF_TLEN_HI) tlen_n = {b, tlen_r[7:0]};
    if (byte_offset_r == OFF_TLEN_LO) tlen_n = {tlen_r[15:8], b};
    ip_len = {10'd0, itsrc_pkg::eff_len(ihl_n)};

    // IPv4 header byte with checksum zeroed and source address rewritten if enabled.
    vb = b;
    if (byte_offset_r == OFF_IPCS_HI || byte_offset_r == OFF_IPCS_LO) vb = 8'd0;
    if (byte_offset_r >= OFF_SRC_LO && byte_offset_r <= OFF_SRC_HI &&
        cfg.replace_address_enable) vb = addr_byte;
    ip_sum_n = (byte_offset_r < ip_len) ?
               itsrc_pkg::oc_add(ip_sum_r, itsrc_pkg::place_byte(byte_offset_r[0], vb)) :
               ip_sum_r;

    // TCP segment byte.
    in_seg  = byte_offset_r >= ip_len;
    seg_off = byte_offset_r - ip_len;
    doff_n  = (in_seg && seg_off == SEG_DOFF) ? b[7:4] : doff_r;
    tcp_hdr = {1'b0, ip_len[5:0]} + {1'b0, itsrc_pkg::eff_len(doff_n)};
    tcp_end = (tlen_n > {9'd0, tcp_hdr}) ? tlen_n : {9'd0, tcp_hdr};
    tv = b;
    if (seg_off == SEG_SPORT_HI && cfg.replace_port_enable) tv = cfg.new_source_port[15:8];
    if (seg_off == SEG_SPORT_LO && cfg.replace_port_enable) tv = cfg.new_source_port[7:0];
    if (seg_off == SEG_CS_HI || seg_off == SEG_CS_LO) tv = 8'd0;

    // Pseudo-header addresses and segment bytes never overlap (segment >= 20).
    in_pseudo = byte_offset_r >= OFF_SRC_LO && byte_offset_r <= OFF_DST_HI;
    if (in_pseudo)
      tcp_sum_n = itsrc_pkg::oc_add(tcp_sum_r, itsrc_pkg::place_byte(byte_offset_r[0], vb));
    else if (in_seg && byte_offset_r < tcp_end)
      tcp_sum_n = itsrc_pkg::oc_add(tcp_sum_r, itsrc_pkg::place_byte(byte_offset_r[0], tv));
    else
      tcp_sum_n = tcp_sum_r;
  end

  // Saturated offset: byte is ignored, state holds.
  always_comb begin
    ihl_u     = active ? ihl_n     : ihl_r;
    doff_u    = active ? doff_n    : doff_r;
    tlen_u    = active ? tlen_n    : tlen_r;
    ip_sum_u  = active ? ip_sum_n  : ip_sum_r;
    tcp_sum_u = active ? tcp_sum_n : tcp_sum_r;
    count_u   = active ? byte_offset_r + 16'd1 : byte_offset_r;
  end

  always_comb begin
    byte_offset_nxt = byte_offset_r;
    ihl_nxt         = ihl_r;
    doff_nxt        = doff_r;
    tlen_nxt        = tlen_r;
    ip_sum_nxt      = ip_sum_r;
    tcp_sum_nxt     = tcp_sum_r;
    fin_valid_nxt   = fin_valid_r && !fin_pop;
    fin_nxt         = fin_r;
    if (take) begin
      if (in_data.last_byte) begin
        byte_offset_nxt      = '0;
        ihl_nxt              = '0;
        doff_nxt             = '0;
        tlen_nxt             = '0;
        ip_sum_nxt           = '0;
        tcp_sum_nxt          = '0;
        fin_valid_nxt        = 1'b1;
        fin_nxt.count        = count_u;
        fin_nxt.ihl          = ihl_u;
        fin_nxt.doff         = doff_u;
        fin_nxt.total_length = tlen_u;
        fin_nxt.ip_sum       = ip_sum_u;
        fin_nxt.tcp_sum      = tcp_sum_u;
      end else begin
        byte_offset_nxt = count_u;
        ihl_nxt         = ihl_u;
        doff_nxt        = doff_u;
        tlen_nxt        = tlen_u;
        ip_sum_nxt      = ip_sum_u;
        tcp_sum_nxt     = tcp_sum_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      ihl_r         <= '0;
      doff_r        <= '0;
      tlen_r        <= '0;
      ip_sum_r      <= '0;
      tcp_sum_r     <= '0;
      fin_valid_r   <= 1'b0;
    end else begin
      byte_offset_r <= byte_offset_nxt;
      ihl_r         <= ihl_nxt;
      doff_r        <= doff_nxt;
      tlen_r        <= tlen_nxt;
      ip_sum_r      <= ip_sum_nxt;
      tcp_sum_r     <= tcp_sum_nxt;
      fin_valid_r   <= fin_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

  assign fin_valid = fin_valid_r;
  assign fin_data  = fin_r;

`ifndef SYNTH
  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_offset_r <= MAX_OFF)
    else $error("byte offset past saturation limit");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_data.last_byte) |=> (fin_valid_r && byte_offset_r == '0 &&
                                     ip_sum_r == '0 && tcp_sum_r == '0))
    else $error("last byte did not close the packet");
`endif

endmodule

### rtl/itsrc_finish.sv
// End-of-packet finisher: length checks, pseudo-header fold, output register.
// Depends on itsrc_pkg.
module itsrc_finish (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fin_valid,
  input  itsrc_pkg::fin_t  fin_data,
  output logic             fin_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output itsrc_pkg::out_t  out_data
);

  logic            out_valid_r, out_valid_nxt;
  itsrc_pkg::out_t out_data_r, out_data_nxt;
  logic            out_load, ok;
  logic [5:0]      ihl4, doff4;
  logic [15:0]     plen, tsum0, tsum;

  assign out_load = !out_valid_r || !out_stall;
  assign fin_pop  = fin_valid && out_load;

  always_comb begin
    ihl4 = {fin_data.ihl, 2'b00};
    doff4 = {fin_data.doff, 2'b00};
    ok = 1'b1;
    if (fin_data.count < itsrc_pkg::MIN_PACKET_BYTES) ok = 1'b0;
    if ({9'd0, {1'b0, ihl4} + itsrc_pkg::IP_MIN_HDR_BYTES} > fin_data.count) ok = 1'b0;
    if (fin_data.total_length > fin_data.count) ok = 1'b0;
    if (fin_data.total_length < {9'd0, {1'b0, ihl4} + {1'b0, doff4}}) ok = 1'b0;

    plen  = fin_data.total_length - {10'd0, itsrc_pkg::eff_len(fin_data.ihl)};
    tsum0 = itsrc_pkg::oc_add(fin_data.tcp_sum, {8'd0, itsrc_pkg::PROTO_TCP});
    tsum  = itsrc_pkg::oc_add(tsum0, plen);

    out_data_nxt.length_ok      = ok;
    out_data_nxt.ip_checksum    = ~fin_data.ip_sum;
    out_data_nxt.tcp_checksum   = ~tsum;
    out_data_nxt.received_bytes = fin_data.count;
  end

  assign out_valid_nxt = out_load ? fin_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    fin_pop |=> out_valid_r)
    else $error("record popped but no result presented");

  a_ok_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.length_ok) |->
      (out_data_r.received_bytes >= itsrc_pkg::MIN_PACKET_BYTES))
    else $error("length_ok set on a runt packet");
`endif

endmodule

### rtl/ipv4_tcp_source_rewrite_checksum_top.sv
// Top level of the IPv4/TCP source-rewrite checksum block: config registers,
// byte accumulator and finisher. Depends on itsrc_pkg, itsrc_accum, itsrc_finish.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one packet byte per request,
//    starting at IPv4 header byte zero; last_byte marks the final byte.
//  - Output channel (out_valid / out_stall / out_data): one request per packet,
//    carrying length_ok, the new IPv4 and TCP checksums and the byte count.
//  - Config port (cfg_we / cfg_index / cfg_wdata): write-only registers for the
//    replacement source address/port and their enables; write only while idle.
//  - Throughput: one byte per cycle, sustained while in_stall is low, back to back
//    across packets. Each byte costs one end-around-carry add per running sum.
//  - Result path: after the last byte is taken, the result is registered in the
//    accumulator record register, then in the output register.
//  - Output stall: the finished record and the output register each hold one
//    result; in_stall rises only while both are full and out_stall is high.
//  - Reset (rst_n low, synchronous): clears config, per-packet state and both
//    valid flags. No clearing pass; the block accepts bytes right after reset.
//  - Byte counter saturates at MAX_PACKET_BYTES; later bytes are ignored except
//    that a last mark still closes the packet.
module ipv4_tcp_source_rewrite_checksum_top #(
  parameter int unsigned MAX_PACKET_BYTES = itsrc_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [itsrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  itsrc_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output itsrc_pkg::out_t                  out_data
);

  itsrc_pkg::cfg_t cfg_r, cfg_nxt;
  itsrc_pkg::fin_t fin_data;
  logic            fin_valid, fin_pop;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (itsrc_pkg::cfg_reg_t'(cfg_index))
        itsrc_pkg::REG_NEW_SRC_ADDR: cfg_nxt.new_source_address     = cfg_wdata;
        itsrc_pkg::REG_NEW_SRC_PORT: cfg_nxt.new_source_port        = cfg_wdata[15:0];
        itsrc_pkg::REG_ADDR_REPL_EN: cfg_nxt.replace_address_enable = cfg_wdata[0];
        itsrc_pkg::REG_PORT_REPL_EN: cfg_nxt.replace_port_enable    = cfg_wdata[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  itsrc_accum #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fin_valid (fin_valid),
    .fin_data  (fin_data),
    .fin_pop   (fin_pop)
  );

  itsrc_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_data  (fin_data),
    .fin_pop   (fin_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && fin_valid))
    else $error("input stalled with room downstream");
`endif

endmodule
